[rtl/core/mlfq_pkg.sv]
package mlfq_pkg;

  localparam int unsigned TaskW    = 8;
  localparam int unsigned BurstW   = 16;
  localparam int unsigned LevelW   = 2;
  localparam int unsigned QuantW   = 10;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned NumLevels = 3;

  localparam logic [QuantW-1:0] Quant0Reset = 10'd10;
  localparam logic [QuantW-1:0] Quant1Reset = 10'd20;

  localparam logic [LevelW-1:0] Level0 = 2'd0;
  localparam logic [LevelW-1:0] Level1 = 2'd1;
  localparam logic [LevelW-1:0] Level2 = 2'd2;

  typedef enum logic {
    ReqArrival = 1'b0,
    ReqTick    = 1'b1
  } req_type_e;

  typedef enum logic [StatusW-1:0] {
    StIdle    = 3'd0,
    StRan     = 3'd1,
    StDone    = 3'd2,
    StDemoted = 3'd3,
    StAccept  = 3'd4,
    StFull    = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgQuantum0 = 2'd0,
    CfgQuantum1 = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    req_type_e         req_type;
    logic [TaskW-1:0]  task_id;
    logic [BurstW-1:0] burst_length;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [TaskW-1:0]  task_id_out;
    logic [LevelW-1:0] level_out;
    logic [BurstW-1:0] remaining_out;
  } rsp_t;

  // One queued task: id and burst ticks still owed.
  typedef struct packed {
    logic [TaskW-1:0]  task_id;
    logic [BurstW-1:0] left;
  } entry_t;

endpackage

[rtl/core/mlfq_fifo.sv]
module mlfq_fifo #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mlfq_pkg::entry_t push_data_i,
  input  logic            pop_i,
  output logic            empty_o,
  output mlfq_pkg::entry_t head_o
);
  import mlfq_pkg::*;

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

  entry_t mem [QUEUE_DEPTH];

  logic [PtrW-1:0] head_ptr_q, head_ptr_d;
  logic [PtrW-1:0] tail_ptr_q, tail_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] rd_addr;
  entry_t          head_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    head_ptr_d = pop_i  ? ptr_next(head_ptr_q) : head_ptr_q;
    tail_ptr_d = push_i ? ptr_next(tail_ptr_q) : tail_ptr_q;
    count_d    = count_q + CntW'(push_i) - CntW'(pop_i);
    rd_addr    = head_ptr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_ptr_q <= '0;
      tail_ptr_q <= '0;
      count_q    <= '0;
    end else begin
      head_ptr_q <= head_ptr_d;
      tail_ptr_q <= tail_ptr_d;
      count_q    <= count_d;
    end
  end

  // Read the next head every cycle; forward a write that lands on it.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[tail_ptr_q] <= push_data_i;
    end
    if (push_i && (tail_ptr_q == rd_addr)) begin
      head_q <= push_data_i;
    end else begin
      head_q <= mem[rd_addr];
    end
  end

  assign empty_o = (count_q == '0);
  assign head_o  = head_q;

endmodule

[rtl/core/mlfq_three_level_scheduler.sv]
// Three-level feedback queue scheduler. Assert start with a word on req_i while
// busy is low; busy never rises, so one word is taken every clock. Exactly one
// result word follows each request on rsp_o, marked by rsp_valid_o for a single
// cycle, in the cycle after the request edge; the receiver cannot stall it, so it
// must take every word as it appears. An arrival enters level 0 or is refused
// when QUEUE_DEPTH tasks are already held (queued plus running). A tick with
// nothing running picks the head of the highest non-empty level, loads that
// level's quantum and runs the task for one tick; level 2 has no quantum.
// Quantum registers are written through the cfg channel (index 0: level 0,
// index 1: level 1, others ignored) and must only be changed while idle.
// Each level queue keeps its head word in a register fed from the queue
// memory, so a pop and the next pick of the same level may follow at once.
module mlfq_three_level_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  mlfq_pkg::req_t                   req_i,
  output logic                             rsp_valid_o,
  output mlfq_pkg::rsp_t                   rsp_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mlfq_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [mlfq_pkg::QuantW-1:0]      cfg_data_i
);
  import mlfq_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(QUEUE_DEPTH);

  // Configuration
  logic [QuantW-1:0] quant0_q, quant1_q;

  // Running task and occupancy
  logic              run_valid_q, run_valid_d;
  logic [TaskW-1:0]  run_task_q,  run_task_d;
  logic [BurstW-1:0] run_left_q,  run_left_d;
  logic [LevelW-1:0] run_level_q, run_level_d;
  logic [QuantW-1:0] qleft_q,     qleft_d;
  logic [CntW-1:0]   held_q,      held_d;

  // Result register
  logic rsp_valid_q, rsp_valid_d;
  rsp_t rsp_q, rsp_d;

  // Level queues
  logic   push [NumLevels];
  logic   pop  [NumLevels];
  logic   empty[NumLevels];
  entry_t head [NumLevels];
  entry_t push_data;

  // Working view of the task that runs this tick
  logic              have;
  logic [TaskW-1:0]  cur_task;
  logic [BurstW-1:0] cur_left;
  logic [LevelW-1:0] cur_level;
  logic [QuantW-1:0] cur_qleft;
  logic [BurstW-1:0] left_dec;

  logic accept;

  assign busy        = 1'b0;
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  for (genvar l = 0; l < NumLevels; l++) begin : g_level
    mlfq_fifo #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_fifo (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .push_i     (push[l]),
      .push_data_i(push_data),
      .pop_i      (pop[l]),
      .empty_o    (empty[l]),
      .head_o     (head[l])
    );
  end

  always_comb begin
    run_valid_d = run_valid_q;
    run_task_d  = run_task_q;
    run_left_d  = run_left_q;
    run_level_d = run_level_q;
    qleft_d     = qleft_q;
    held_d      = held_q;
    rsp_valid_d = 1'b0;
    rsp_d       = '0;
    push_data   = '0;
    for (int l = 0; l < NumLevels; l++) begin
      push[l] = 1'b0;
      pop[l]  = 1'b0;
    end

    have      = run_valid_q;
    cur_task  = run_task_q;
    cur_left  = run_left_q;
    cur_level = run_level_q;
    cur_qleft = qleft_q;
    left_dec  = run_left_q - BurstW'(1);

    if (accept) begin
      rsp_valid_d = 1'b1;
      if (req_i.req_type == ReqArrival) begin
        rsp_d.task_id_out   = req_i.task_id;
        rsp_d.remaining_out = req_i.burst_length;
        if (held_q >= DepthCnt) begin
          // Refuse: a full block changes nothing
          rsp_d.status = StFull;
        end else begin
          push[0]           = 1'b1;
          push_data.task_id = req_i.task_id;
          push_data.left    = req_i.burst_length;
          held_d            = held_q + CntW'(1);
          rsp_d.status      = StAccept;
        end
      end else begin
        // Pick a new task from the highest non-empty level when idle
        if (!run_valid_q) begin
          have = 1'b1;
          priority if (!empty[0]) begin
            pop[0]    = 1'b1;
            cur_task  = head[0].task_id;
            cur_left  = head[0].left;
            cur_level = Level0;
            cur_qleft = quant0_q;
          end else if (!empty[1]) begin
            pop[1]    = 1'b1;
            cur_task  = head[1].task_id;
            cur_left  = head[1].left;
            cur_level = Level1;
            cur_qleft = quant1_q;
          end else if (!empty[2]) begin
            pop[2]    = 1'b1;
            cur_task  = head[2].task_id;
            cur_left  = head[2].left;
            cur_level = Level2;
            cur_qleft = '0;
          end else begin
            have = 1'b0;
          end
        end
        left_dec = cur_left - BurstW'(1);

        rsp_d.task_id_out = cur_task;
        rsp_d.level_out   = cur_level;
        run_task_d        = cur_task;
        run_level_d       = cur_level;
        qleft_d           = cur_qleft;

        if (!have) begin
          rsp_d       = '0;
          rsp_d.status = StIdle;
          run_task_d  = run_task_q;
          run_level_d = run_level_q;
          qleft_d     = qleft_q;
        end else if (cur_left <= BurstW'(1)) begin
          // Complete: last burst unit used (a zero burst completes too)
          run_valid_d         = 1'b0;
          run_left_d          = '0;
          held_d              = held_q - CntW'(1);
          rsp_d.status        = StDone;
          rsp_d.remaining_out = '0;
        end else begin
          run_left_d          = left_dec;
          rsp_d.remaining_out = left_dec;
          run_valid_d         = 1'b1;
          rsp_d.status        = StRan;
          if (cur_level != Level2) begin
            if (cur_qleft <= QuantW'(1)) begin
              // Slice expired: demote one level, a zero quantum acts as one
              qleft_d           = '0;
              run_valid_d       = 1'b0;
              push_data.task_id = cur_task;
              push_data.left    = left_dec;
              rsp_d.status      = StDemoted;
              if (cur_level == Level0) begin
                push[1] = 1'b1;
              end else begin
                push[2] = 1'b1;
              end
            end else begin
              qleft_d = cur_qleft - QuantW'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quant0_q <= Quant0Reset;
      quant1_q <= Quant1Reset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgQuantum0: quant0_q <= cfg_data_i;
        CfgQuantum1: quant1_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_valid_q <= 1'b0;
      run_task_q  <= '0;
      run_left_q  <= '0;
      run_level_q <= '0;
      qleft_q     <= '0;
      held_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      run_valid_q <= run_valid_d;
      run_task_q  <= run_task_d;
      run_left_q  <= run_left_d;
      run_level_q <= run_level_d;
      qleft_q     <= qleft_d;
      held_q      <= held_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Result word: payload only, the strobe carries validity
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

[tb/mlfq_sched_checker.sv]
module mlfq_sched_checker #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               busy_i,
  input  mlfq_pkg::req_t                     req_i,
  input  logic                               rsp_valid_i,
  input  mlfq_pkg::rsp_t                     rsp_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [mlfq_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [mlfq_pkg::QuantW-1:0]        cfg_data_i,
  output int                                 errors_o,
  output int                                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mlfq_pkg::*;

  localparam int unsigned PrintCap = 30;

  // Own copy of the scheduler state.
  logic [QuantW-1:0] quant0, quant1;
  entry_t            ring [NumLevels][QUEUE_DEPTH];
  int unsigned       head [NumLevels];
  int unsigned       fill [NumLevels];
  int unsigned       held;
  bit                running;
  logic [TaskW-1:0]  cur_task;
  logic [BurstW-1:0] cur_left;
  logic [LevelW-1:0] cur_level;
  logic [QuantW-1:0] slice_left;

  rsp_t due_rsp_q [$];
  int   mismatches;

  assign errors_o = mismatches;

  // Print only the first few, count them all.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < PrintCap) begin
      $display("%0t sched check: %s got %0h want %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  function automatic void enqueue(input int unsigned lv, input logic [TaskW-1:0] id,
                                  input logic [BurstW-1:0] left);
    ring[lv][(head[lv] + fill[lv]) % QUEUE_DEPTH] = '{task_id: id, left: left};
    fill[lv]++;
  endfunction

  function automatic rsp_t schedule_word(input req_t w);
    rsp_t        r;
    entry_t      e;
    int unsigned lv;
    r = '0;
    if (w.req_type == ReqArrival) begin
      r.task_id_out   = w.task_id;
      r.level_out     = Level0;
      r.remaining_out = w.burst_length;
      if (held >= QUEUE_DEPTH) begin
        r.status = StFull;
        return r;
      end
      enqueue(Level0, w.task_id, w.burst_length);
      held++;
      r.status = StAccept;
      return r;
    end
    if (!running) begin
      lv = 0;
      while (lv < NumLevels && fill[lv] == 0) lv++;
      if (lv == NumLevels) begin
        r.status = StIdle;
        return r;
      end
      e        = ring[lv][head[lv]];
      head[lv] = (head[lv] + 1) % QUEUE_DEPTH;
      fill[lv]--;
      running   = 1'b1;
      cur_task  = e.task_id;
      cur_left  = e.left;
      cur_level = LevelW'(lv);
      slice_left = (cur_level == Level0) ? quant0 :
                   (cur_level == Level1) ? quant1 : '0;
    end
    r.task_id_out = cur_task;
    r.level_out   = cur_level;
    if (cur_left <= 1) begin
      cur_left = '0;
      running  = 1'b0;
      held--;
      r.status = StDone;
      return r;
    end
    cur_left--;
    r.remaining_out = cur_left;
    if (cur_level != Level2) begin
      if (slice_left <= 1) begin
        slice_left = '0;
        enqueue(cur_level + 1, cur_task, cur_left);
        running  = 1'b0;
        r.status = StDemoted;
        return r;
      end
      slice_left--;
    end
    r.status = StRan;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      quant0     = Quant0Reset;
      quant1     = Quant1Reset;
      held       = 0;
      running    = 1'b0;
      cur_task   = '0;
      cur_left   = '0;
      cur_level  = Level0;
      slice_left = '0;
      for (int i = 0; i < NumLevels; i++) begin
        head[i] = 0;
        fill[i] = 0;
      end
      due_rsp_q.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      // Results first: the one due now was queued at an earlier edge.
      if (rsp_valid_i) begin
        if (due_rsp_q.size() == 0) begin
          report_mismatch("result word with none due", rsp_i, '0);
        end else begin
          want = due_rsp_q.pop_front();
          if (rsp_i.status !== want.status)
            report_mismatch("status", rsp_i.status, want.status);
          if (rsp_i.task_id_out !== want.task_id_out)
            report_mismatch("task_id_out", rsp_i.task_id_out, want.task_id_out);
          if (rsp_i.level_out !== want.level_out)
            report_mismatch("level_out", rsp_i.level_out, want.level_out);
          if (rsp_i.remaining_out !== want.remaining_out)
            report_mismatch("remaining_out", rsp_i.remaining_out, want.remaining_out);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgQuantum0: quant0 = cfg_data_i;
          CfgQuantum1: quant1 = cfg_data_i;
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        due_rsp_q.push_back(schedule_word(req_i));
      end
      pending_o <= due_rsp_q.size();
    end
  end

endmodule

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mlfq_pkg::*;

  localparam int unsigned Depth      = 64;
  localparam int unsigned ItemTarget = 650;
  localparam int unsigned NumPhases  = 6;
  // Far longer than the longest sender gap; a quiet spell this long is a hang.
  localparam int unsigned StallLimit = 500;
  // Index that maps to no register; writes to it must change nothing.
  localparam logic [CfgIdxW-1:0] CfgNoReg = 2'd3;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  req_t               req_i;
  logic               rsp_valid_o;
  rsp_t               rsp_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [QuantW-1:0]  cfg_data_i;

  int          mismatch_total;
  int          words_due;
  int unsigned item_count;
  int unsigned idle_cycles;
  bit          gaps_on;

  mlfq_three_level_scheduler #(
    .QUEUE_DEPTH(Depth)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Watch every channel, predict each result word and compare.
  mlfq_sched_checker #(
    .QUEUE_DEPTH(Depth)
  ) u_sched_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .req_i       (req_i),
    .rsp_valid_i (rsp_valid_o),
    .rsp_i       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (mismatch_total),
    .pending_o   (words_due)
  );

  // 20 ns period.
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Count cycles in which no word moves on any channel; give up at the limit.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || rsp_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Keep bursts short so the queues keep moving; a few are long enough to
  // sink to level 2 under the default quanta.
  function automatic logic [BurstW-1:0] pick_burst();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 75) return BurstW'($urandom_range(1, 8));
    if (r < 95) return BurstW'($urandom_range(9, 80));
    return BurstW'($urandom_range(81, 300));
  endfunction

  // Present one word and hold it until the edge that takes it. A word that
  // follows at once keeps start high, so start is never dropped and raised
  // within the same step.
  task automatic send_word(input req_t w);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= w;
    do @(posedge clk_i); while (busy);
    item_count++;
  endtask

  task automatic arrive(input logic [TaskW-1:0] id, input logic [BurstW-1:0] burst);
    req_t w;
    w.req_type     = ReqArrival;
    w.task_id      = id;
    w.burst_length = burst;
    send_word(w);
  endtask

  // The id and burst fields are don't-care on a tick: fill them with noise.
  task automatic tick_once();
    req_t w;
    w.req_type     = ReqTick;
    w.task_id      = TaskW'($urandom_range(0, 255));
    w.burst_length = BurstW'($urandom_range(0, 65535));
    send_word(w);
  endtask

  task automatic ticks(input int unsigned n);
    repeat (n) tick_once();
  endtask

  // Drop start and wait until every result word due has come back. Each
  // word yields exactly one result in the following cycle, so nothing is still in
  // flight once the count reaches zero.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (words_due != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [QuantW-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_quanta(input logic [QuantW-1:0] q0, input logic [QuantW-1:0] q1);
    write_reg(CfgQuantum0, q0);
    write_reg(CfgQuantum1, q1);
  endtask

  // Fill the block with no tick in between, so it is certainly full by the
  // last tasks; the extra arrivals are refused and carry full-range bursts.
  task automatic flood();
    gaps_on = ($urandom_range(0, 1) != 0);
    repeat (Depth) arrive(TaskW'($urandom_range(0, 255)), BurstW'($urandom_range(0, 3)));
    repeat (3) arrive(TaskW'($urandom_range(0, 255)), BurstW'($urandom_range(0, 65535)));
  endtask

  // Mostly a batch of arrivals followed by enough ticks to work through it,
  // sometimes a pure run of ticks, sometimes a loose mix.
  task automatic random_sequence();
    int unsigned kind;
    gaps_on = ($urandom_range(0, 3) != 0);
    kind    = $urandom_range(0, 9);
    if (kind < 6) begin
      repeat ($urandom_range(1, 6)) arrive(TaskW'($urandom_range(0, 255)), pick_burst());
      ticks($urandom_range(10, 60));
    end else if (kind < 9) begin
      ticks($urandom_range(10, 80));
    end else begin
      repeat (20) begin
        if ($urandom_range(0, 1) != 0) arrive(TaskW'($urandom_range(0, 255)), pick_burst());
        else tick_once();
      end
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    gaps_on     = 1'b0;
    item_count  = 0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset quanta 10 and 20.
    tick_once();                   // nothing to run: idle word
    arrive(8'h00, 16'h0000);       // zero burst
    tick_once();                   // completes on its first tick
    arrive(8'hFF, 16'd3);
    arrive(8'hA5, 16'd1);
    ticks(5);                      // FF runs out, A5 completes, then idle

    // Zero quantum behaves as one; a write to an unmapped index is dropped.
    set_quanta('0, 10'd2);
    write_reg(CfgNoReg, 10'h3FF);
    arrive(8'h5A, 16'd6);
    ticks(6);                      // demote from 0, run and demote at 1, finish at 2

    // Random part, one quantum setting per phase, the extremes among them.
    for (int unsigned p = 0; p < NumPhases; p++) begin
      case (p)
        0: set_quanta(10'd1, 10'd1);
        1: set_quanta(10'h3FF, 10'h3FF);
        2: begin
          set_quanta('0, '0);
          write_reg(CfgNoReg, QuantW'($urandom_range(0, 1023)));
        end
        3: set_quanta(10'd4, 10'd7);
        4: set_quanta(QuantW'($urandom_range(1, 1023)), QuantW'($urandom_range(1, 1023)));
        default: set_quanta(Quant0Reset, Quant1Reset);
      endcase
      if (p == 0 || p == 2) flood();
      while (item_count < 18 + (p + 1) * ((ItemTarget - 18) / NumPhases)) random_sequence();
    end

    settle();
    repeat (3) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
